// File: rtl/max_pool_2x2_stride1_core_defines.svh
// ----------------------------------------------------------------------------
// max_pool_2x2_stride1_core_defines
// Assertion macros shared by the 2x2 max pooling RTL
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2X2_STRIDE1_CORE_DEFINES_SVH
`define MAX_POOL_2X2_STRIDE1_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mp2x2_pkg.sv
// ----------------------------------------------------------------------------
// mp2x2_pkg
// Types and constants of the 2x2 stride-1 max pooling core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mp2x2_pkg;

	// configuration register widths
	localparam int WIDTH_REG_BITS  = 13;
	localparam int HEIGHT_REG_BITS = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 1;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

	// reset values and smallest useful frame dimension
	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd4096;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd4096;
	localparam int                         MIN_DIM      = 2;

	// per-item flags carried from the input stage to the result stage
	typedef struct packed {
		logic produce;
		logic row_end;
		logic frame_end;
	} pool_flags_t;

endpackage

`default_nettype wire

// File: rtl/max_pool_2x2_stride1_core.sv
// ----------------------------------------------------------------------------
// max_pool_2x2_stride1_core
// 2x2 max pooling with stride 1 over a raster stream of signed samples
// ----------------------------------------------------------------------------
//  channel   direction  transaction                      fields (low bit up)
//  s_axis    in         one input sample                 tdata: sample
//  m_axis    out        one pooled result                tdata: pooled_value,
//                                                        tlast: row_end,
//                                                        tuser: frame_end
//  cfg       in         register write, no wait          0 image_width,
//                                                        1 image_height
//
// One sample per cycle unless stalled; results pass s1 and the result register.
// The line store is a single-port read-first memory read and written at the
// input register, so the read-to-use delay of the memory sets the latency.
// Reset clears counters, valid bits and the window registers; the line store
// is not cleared; its reads in the first row, which writes it, are not used.
// A stalled output holds the result register; one more sample is taken while
// a result waits, then s_axis_tready drops until the output moves.
// A register write restarts the frame counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "max_pool_2x2_stride1_core_defines.svh"

module max_pool_2x2_stride1_core #(
	parameter int MAX_WIDTH   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input stream
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample
	// output stream
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output      logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // pooled_value
	output      logic                                  m_axis_tlast,  // row_end
	output      logic                                  m_axis_tuser,  // frame_end
	// configuration write
	input  wire logic                                  cfg_we,
	input  wire logic [mp2x2_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [mp2x2_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	localparam int SB  = SAMPLE_BITS;
	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WB  = (mp2x2_pkg::WIDTH_REG_BITS > AW + 1) ?
	                     mp2x2_pkg::WIDTH_REG_BITS : AW + 1;
	localparam int HB  = mp2x2_pkg::HEIGHT_REG_BITS;

	// configuration and frame position
	logic [mp2x2_pkg::WIDTH_REG_BITS-1:0] width_q;
	logic [HB-1:0]                        height_q;
	logic [AW-1:0]                        col_q;
	logic [HB-1:0]                        row_q;

	// window registers
	logic [SB-1:0] left_q;
	logic [SB-1:0] upper_left_q;

	// input stage
	logic                   valid_s1;
	logic [SB-1:0]          sample_s1;
	logic [SB-1:0]          above_s1;
	mp2x2_pkg::pool_flags_t flags_s1;

	// result register
	logic          out_valid_q;
	logic [SB-1:0] out_value_q;
	logic          out_row_end_q;
	logic          out_frame_end_q;

	// line store
	logic [SB-1:0] line_mem [MAX_WIDTH];

	logic                   in_acc;
	logic                   adv_s1;
	logic [WB-1:0]          w_ext;
	logic [WB-1:0]          w_act;
	logic [HB-1:0]          h_act;
	logic [WB-1:0]          col_ext;
	logic [WB-1:0]          col_eff;
	logic [AW-1:0]          addr;
	logic                   col_last;
	logic                   row_last;
	logic [AW-1:0]          col_next;
	logic [HB-1:0]          row_next;
	mp2x2_pkg::pool_flags_t flags_in;
	logic [SB-1:0]          in_sample;
	logic [SB-1:0]          max_top;
	logic [SB-1:0]          max_bot;
	logic [SB-1:0]          max_all;

	function automatic logic [SB-1:0] smax(input logic [SB-1:0] a, input logic [SB-1:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	// handshake
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_sample     = s_axis_tdata[SB-1:0];

	// active frame size and position
	always_comb begin
		w_ext = WB'(width_q);
		if (w_ext < WB'(mp2x2_pkg::MIN_DIM)) begin
			w_act = WB'(mp2x2_pkg::MIN_DIM);
		end else if (w_ext > WB'(MAX_WIDTH)) begin
			w_act = WB'(MAX_WIDTH);
		end else begin
			w_act = w_ext;
		end
		h_act   = (height_q < HB'(mp2x2_pkg::MIN_DIM)) ? HB'(mp2x2_pkg::MIN_DIM) : height_q;
		col_ext = WB'(col_q);
		col_eff = (col_ext >= w_act) ? (w_act - WB'(1)) : col_ext;
		addr    = col_eff[AW-1:0];
		col_last = (col_eff == w_act - WB'(1));
		row_last = (row_q >= h_act - HB'(1));
		col_next = col_last ? '0 : (addr + AW'(1));
		row_next = row_last ? '0 : (row_q + HB'(1));
		flags_in.produce   = (row_q != '0) && (col_eff != '0);
		flags_in.row_end   = col_last;
		flags_in.frame_end = col_last && row_last;
	end

	// configuration registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mp2x2_pkg::WIDTH_RESET;
			height_q <= mp2x2_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mp2x2_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_wdata[mp2x2_pkg::WIDTH_REG_BITS-1:0];
				mp2x2_pkg::CFG_IDX_HEIGHT: height_q <= cfg_wdata[HB-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			col_q <= col_next;
			if (col_last) begin
				row_q <= row_next;
			end
		end
	end

	// line store, read-first single port
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1       <= line_mem[addr];
			line_mem[addr] <= in_sample;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= in_sample;
			flags_s1  <= flags_in;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// window maximum
	always_comb begin
		max_top = smax(upper_left_q, above_s1);
		max_bot = smax(left_q, sample_s1);
		max_all = smax(max_top, max_bot);
	end

	// window registers shift when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (adv_s1) begin
			left_q       <= sample_s1;
			upper_left_q <= above_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && flags_s1.produce) begin
			out_value_q     <= max_all;
			out_row_end_q   <= flags_s1.row_end;
			out_frame_end_q <= flags_s1.frame_end;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && flags_s1.produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDW'(out_value_q);
	assign m_axis_tlast  = out_row_end_q;
	assign m_axis_tuser  = out_frame_end_q;

	// checks
	`MP_ASSERT_NXT(a_acc_fills_s1, in_acc, valid_s1, "accepted sample missing from input stage")
	`MP_ASSERT_NXT(a_result_loaded, adv_s1 && flags_s1.produce, out_valid_q, "window result lost")
	`MP_ASSERT_IMP(a_col_in_range, 1'b1, col_ext < w_act, "column counter beyond active width")
	`MP_ASSERT_NXT(a_cfg_restart, cfg_we, col_q == '0 && row_q == '0, "frame not restarted on write")
	`MP_ASSERT_IMP(a_frame_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end off row end")

endmodule

`default_nettype wire
